[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/sfcd_pkg.sv]
// ----------------------------------------------------------------------------
// sfcd_pkg
// Constants and CRC helper for the sensor frame CRC decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

   localparam logic [15:0] CrcInit     = 16'hFFFF;
   localparam logic [15:0] CrcPoly     = 16'hA001;
   localparam logic [2:0]  CrcSpan     = 3'd6;
   localparam logic [15:0] TempReset   = 16'd400;
   localparam logic [15:0] HumidReset  = 16'd300;

   // byte positions within a frame
   localparam logic [2:0] PosHumidHi = 3'd2;
   localparam logic [2:0] PosHumidLo = 3'd3;
   localparam logic [2:0] PosTempHi  = 3'd4;
   localparam logic [2:0] PosTempLo  = 3'd5;
   localparam logic [2:0] PosCrcLo   = 3'd6;
   localparam logic [2:0] PosCrcHi   = 3'd7;

   // CRC-16/MODBUS update over one byte, LSB first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[sv/sensor_frame_crc_decoder_core.sv]
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder_core
// Byte-wise decoder for 8-byte temperature/humidity sensor frames.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle and checks CRC-16/MODBUS over bytes 0-5
// against the little-endian CRC in bytes 6-7. A result word is registered
// when the eighth byte is accepted and appears in the next cycle, carrying
// the CRC status and the held humidity/temperature, which change only on
// a good frame. Bytes can be accepted every cycle; the single result
// register is the only stall source, so req_stall rises only while a
// result sits unaccepted under rsp_stall. frame_start restarts the byte
// count and CRC and drops any partial frame.
module sensor_frame_crc_decoder_core
   import sfcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_crc_ok,
   output logic signed [15:0] rsp_temperature_tenths,
   output logic [15:0]        rsp_humidity_tenths
);

   logic [2:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] humid_cap_ff, humid_cap_in;
   logic [15:0] temp_cap_ff, temp_cap_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [15:0] temp_held_ff, temp_held_in;
   logic [15:0] humid_held_ff, humid_held_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ok_ff, rsp_ok_in;

   logic        accept;
   logic [2:0]  pos;
   logic [15:0] crc_base;
   logic [15:0] mag;
   logic        crc_match;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign pos       = req_frame_start ? 3'd0 : count_ff;
   assign crc_base  = req_frame_start ? CrcInit : crc_ff;
   assign crc_match = ({req_rx_byte, crc_lo_ff} == crc_ff);
   assign mag       = {1'b0, temp_cap_ff[14:0]};

   always_comb begin
      count_in      = count_ff;
      crc_in        = crc_ff;
      humid_cap_in  = humid_cap_ff;
      temp_cap_in   = temp_cap_ff;
      crc_lo_in     = crc_lo_ff;
      temp_held_in  = temp_held_ff;
      humid_held_in = humid_held_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;

      if (accept) begin
         count_in = pos + 3'd1;
         crc_in   = (pos < CrcSpan) ? crc16_byte(crc_base, req_rx_byte) : crc_base;
         unique case (pos)
            PosHumidHi: humid_cap_in = {req_rx_byte, humid_cap_ff[7:0]};
            PosHumidLo: humid_cap_in = {humid_cap_ff[15:8], req_rx_byte};
            PosTempHi:  temp_cap_in  = {req_rx_byte, temp_cap_ff[7:0]};
            PosTempLo:  temp_cap_in  = {temp_cap_ff[15:8], req_rx_byte};
            PosCrcLo:   crc_lo_in    = req_rx_byte;
            default: ;
         endcase
         if (pos == PosCrcHi) begin
            // last byte: compare, update held values on a match, restart CRC
            crc_in       = CrcInit;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = crc_match;
            if (crc_match) begin
               temp_held_in  = temp_cap_ff[15] ? (16'd0 - mag) : mag;
               humid_held_in = humid_cap_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= 3'd0;
         crc_ff        <= CrcInit;
         humid_cap_ff  <= 16'd0;
         temp_cap_ff   <= 16'd0;
         crc_lo_ff     <= 8'd0;
         temp_held_ff  <= TempReset;
         humid_held_ff <= HumidReset;
         rsp_valid_ff  <= 1'b0;
         rsp_ok_ff     <= 1'b0;
      end else begin
         count_ff      <= count_in;
         crc_ff        <= crc_in;
         humid_cap_ff  <= humid_cap_in;
         temp_cap_ff   <= temp_cap_in;
         crc_lo_ff     <= crc_lo_in;
         temp_held_ff  <= temp_held_in;
         humid_held_ff <= humid_held_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_ok_ff     <= rsp_ok_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_crc_ok             = rsp_ok_ff;
   assign rsp_temperature_tenths = temp_held_ff;
   assign rsp_humidity_tenths    = humid_held_ff;

endmodule

[sv/sfcd_checker.sv]
// ----------------------------------------------------------------------------
// sfcd_checker
// Port-level checks for the sensor frame CRC decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfcd_checker
   import sfcd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_crc_ok,
   input logic signed [15:0] rsp_temperature_tenths,
   input logic [15:0]        rsp_humidity_tenths
);

   // input side stalls only behind a held result word
   `ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "req_stall without held result")

   // a new result needs a byte accepted the cycle before
   `ASSERT_IMPLY(a_rsp_from_req, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall), "result without input word")

   // magnitude is 15 bits, so the most negative code never appears
   `ASSERT_IMPLY(a_temp_range, clock, reset, rsp_valid, rsp_temperature_tenths != 16'sh8000, "temperature out of range")

   // held result word does not move
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_crc_ok) && $stable(rsp_temperature_tenths) && $stable(rsp_humidity_tenths), "stalled result changed")

endmodule

bind sensor_frame_crc_decoder_core sfcd_checker u_sfcd_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_crc_ok             (rsp_crc_ok),
   .rsp_temperature_tenths (rsp_temperature_tenths),
   .rsp_humidity_tenths    (rsp_humidity_tenths)
);
